// ----- hdl/krt_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_pkg: shared types and codes for the keyed record table
// Action and status codes, the record layout and the cell control bundle.
// ----------------------------------------------------------------------------
package krt_pkg;

    localparam int KEY_W   = 32;
    localparam int PRICE_W = 32;
    localparam int QTY_W   = 32;
    localparam int ACT_W   = 2;
    localparam int STAT_W  = 2;
    localparam int CNTF_W  = 8;

    // action codes
    localparam logic [ACT_W-1:0] ACT_ADD    = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOOKUP = 2'd1;
    localparam logic [ACT_W-1:0] ACT_UPDATE = 2'd2;
    localparam logic [ACT_W-1:0] ACT_REMOVE = 2'd3;

    // status codes
    localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd2;

    // one stored record
    typedef struct packed {
        logic        [KEY_W-1:0]   key;
        logic        [PRICE_W-1:0] price;
        logic signed [QTY_W-1:0]   qty;
    } t_entry;

    // control broadcast to every cell
    typedef struct packed {
        logic             capture;  // latch match flags against cap_key
        logic [KEY_W-1:0] cap_key;
        logic             apply;    // perform the held action
        logic [ACT_W-1:0] action;
        t_entry           rec;      // record carried by the held command
    } t_cell_ctl;

endpackage

// ----- hdl/krt_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// krt_cell: one slot of the record table
// Holds a record and its match flag; passes the first-hit chain on and takes
// its upper neighbour's record when a removal closes the gap.
// ----------------------------------------------------------------------------
module krt_cell (
    input  logic              i_clk,
    input  krt_pkg::t_cell_ctl i_ctl,
    input  logic              i_occupied,  // slot lies below the entry count
    input  logic              i_is_tail,   // slot is the next free one
    input  logic              i_hit_in,    // a lower slot already matched
    input  krt_pkg::t_entry   i_nxt,       // record of the slot above
    output logic              o_hit_out,
    output logic              o_first,
    output krt_pkg::t_entry   o_entry
);
    import krt_pkg::*;

    t_entry r_entry;
    logic   r_match;

    // first-hit chain
    assign o_first   = r_match & ~i_hit_in;
    assign o_hit_out = r_match | i_hit_in;
    assign o_entry   = r_entry;

    // key compare, taken on the accepting beat
    always_ff @(posedge i_clk) begin
        if (i_ctl.capture) begin
            r_match <= i_occupied && (r_entry.key == i_ctl.cap_key);
        end
    end

    // record update
    always_ff @(posedge i_clk) begin
        if (i_ctl.apply) begin
            case (i_ctl.action)
                ACT_ADD: begin
                    if (i_is_tail) begin
                        r_entry <= i_ctl.rec;
                    end
                end
                ACT_UPDATE: begin
                    if (o_first) begin
                        r_entry.price <= i_ctl.rec.price;
                        r_entry.qty   <= i_ctl.rec.qty;
                    end
                end
                ACT_REMOVE: begin
                    // this slot and all above the hit move down by one
                    if (o_hit_out) begin
                        r_entry <= i_nxt;
                    end
                end
                default: begin
                end
            endcase
        end
    end

endmodule

// ----- hdl/keyed_record_table_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// keyed_record_table_top: fixed-capacity keyed record table
// A new beat is accepted only once the previous command has been applied. The
// accepting beat registers the key compare in every cell at once; the apply
// state resolves the first hit along the cell chain, applies the action and
// registers the result. Reset (synchronous, active low) empties the table and
// the output stage; record contents are not cleared.
// ----------------------------------------------------------------------------
module keyed_record_table_top #(
    parameter int TABLE_DEPTH = 128
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    // [31:0] record_key, [63:32] price_cents, [95:64] stock_quantity
    input  logic [95:0]  i_s_axis_tdata,
    // [1:0] action
    input  logic [1:0]   i_s_axis_tuser,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // [31:0] found_price, [63:32] found_quantity, [71:64] stored_count
    output logic [71:0]  o_m_axis_tdata,
    // [1:0] status
    output logic [1:0]   o_m_axis_tuser
);
    import krt_pkg::*;

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_APPLY = 1'b1;

    logic             r_state, n_state;
    logic [CNT_W-1:0] r_count, n_count;
    logic [ACT_W-1:0] r_action;
    t_entry           r_cmd;
    logic             r_out_valid, n_out_valid;
    logic [STAT_W-1:0] r_out_status, n_out_status;
    t_entry           r_out_rec, n_out_rec;

    t_cell_ctl        w_ctl;
    logic             w_accept;
    logic [TABLE_DEPTH:0]  w_hit;
    logic [TABLE_DEPTH-1:0] w_first;
    t_entry           w_entry [TABLE_DEPTH];
    t_entry           w_found;
    t_entry           w_in_rec;

    assign w_in_rec.key   = i_s_axis_tdata[31:0];
    assign w_in_rec.price = i_s_axis_tdata[63:32];
    assign w_in_rec.qty   = i_s_axis_tdata[95:64];

    // accept only when idle and the output stage is free by the apply beat
    assign o_s_axis_tready = (r_state == S_IDLE) && (!r_out_valid || i_m_axis_tready);
    assign w_accept        = i_s_axis_tvalid && o_s_axis_tready;

    // broadcast to cells
    always_comb begin
        w_ctl.capture = w_accept;
        w_ctl.cap_key = w_in_rec.key;
        w_ctl.apply   = (r_state == S_APPLY);
        w_ctl.action  = r_action;
        w_ctl.rec     = r_cmd;
    end

    // cell chain
    assign w_hit[0] = 1'b0;
    for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
        t_entry w_nxt;
        if (g == TABLE_DEPTH - 1) begin : g_last
            assign w_nxt = '0;
        end else begin : g_mid
            assign w_nxt = w_entry[g+1];
        end
        krt_cell u_cell (
            .i_clk      (i_clk),
            .i_ctl      (w_ctl),
            .i_occupied (r_count > CNT_W'(g)),
            .i_is_tail  (r_count == CNT_W'(g)),
            .i_hit_in   (w_hit[g]),
            .i_nxt      (w_nxt),
            .o_hit_out  (w_hit[g+1]),
            .o_first    (w_first[g]),
            .o_entry    (w_entry[g])
        );
    end

    // gather the first hit's record (at most one cell is selected)
    always_comb begin
        w_found = '0;
        for (int i = 0; i < TABLE_DEPTH; i++) begin
            w_found = w_found | (w_first[i] ? w_entry[i] : t_entry'('0));
        end
    end

    // control and result
    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_rec    = r_out_rec;
        if (r_out_valid && i_m_axis_tready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_APPLY;
                end
            end
            S_APPLY: begin
                n_state      = S_IDLE;
                n_out_valid  = 1'b1;
                n_out_status = ST_OK;
                n_out_rec    = '0;
                if (r_action == ACT_ADD) begin
                    if (r_count == CNT_W'(TABLE_DEPTH)) begin
                        n_out_status = ST_FULL;
                    end else begin
                        n_out_rec = r_cmd;
                        n_count   = r_count + CNT_W'(1);
                    end
                end else if (!w_hit[TABLE_DEPTH]) begin
                    n_out_status = ST_NOT_FOUND;
                end else if (r_action == ACT_UPDATE) begin
                    n_out_rec = r_cmd;
                end else begin
                    n_out_rec = w_found;
                    if (r_action == ACT_REMOVE) begin
                        n_count = r_count - CNT_W'(1);
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= i_s_axis_tuser;
            r_cmd    <= w_in_rec;
        end
        r_out_status <= n_out_status;
        r_out_rec    <= n_out_rec;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_status;
    assign o_m_axis_tdata  = {CNTF_W'(r_count), r_out_rec.qty, r_out_rec.price};

endmodule
